### sv/dnsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsd_pkg
// Shared types and constants for the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnsd_pkg;

    localparam int MSG_BYTES_DEF = 512;
    localparam int MAX_NAME_DEF  = 255;

    localparam int POS_W    = 17;
    localparam int NAME_W   = 8;
    localparam int JUMP_W   = 6;
    localparam int ADDR_W   = 9;
    localparam int BYTE_W   = 8;
    localparam int CHARS_W  = 32;
    localparam int CNT_W    = 3;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 48;
    localparam int PADDR_W  = 2;
    localparam int PDATA_W  = 32;

    localparam logic [BYTE_W-1:0] PTR_MARK    = 8'd192;
    localparam logic [BYTE_W-1:0] DOT_CHAR    = 8'h2E;
    localparam logic [JUMP_W-1:0] JUMPS_RESET = 6'd16;
    localparam logic [CNT_W-1:0]  PACK_FULL   = 3'd4;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_DECODE = 1'b1
    } t_command;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_LONG  = 2'd1,
        ST_JUMPS = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_HEAD,
        S_PTR,
        S_CHAR,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic    load_wr;
        logic    init;
        logic    rd_pos;
        logic    rd_pos1;
        logic    ptr_hi;
        logic    ptr_take;
        logic    head_zero;
        logic    head_label;
        logic    char_adv;
        logic    put_dot;
        logic    put_byte;
        logic    set_status;
        t_status status_code;
        logic    emit_final;
    } t_cmd;

    typedef struct packed {
        logic pos_out;
        logic pos1_out;
        logic rem_zero;
        logic byte_zero;
        logic byte_ptr;
        logic jumps_hit;
        logic first;
        logic name_full;
        logic fill_full;
        logic out_free;
    } t_sts;

endpackage

### sv/dnsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dnsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/dnsd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsd_datapath
// Message store, walk registers, character packer and output register.
// ----------------------------------------------------------------------------
module dnsd_datapath #(
    parameter int MSG_BYTES = dnsd_pkg::MSG_BYTES_DEF,
    parameter int MAX_NAME  = dnsd_pkg::MAX_NAME_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dnsd_pkg::t_cmd                i_cmd,
    output dnsd_pkg::t_sts                o_sts,
    input  logic [dnsd_pkg::ADDR_W-1:0]   i_address,
    input  logic [dnsd_pkg::BYTE_W-1:0]   i_byte_value,
    input  logic [dnsd_pkg::ADDR_W-1:0]   i_start_offset,
    input  logic                          i_cfg_we,
    input  logic [dnsd_pkg::JUMP_W-1:0]   i_cfg_jumps,
    output logic [dnsd_pkg::JUMP_W-1:0]   o_max_jumps,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dnsd_pkg::OUT_W-1:0]    o_out_data,
    output logic                          o_out_last
);

    import dnsd_pkg::*;

    localparam int AW = $clog2(MSG_BYTES);
    localparam logic [POS_W-1:0]  MSG_END  = POS_W'(MSG_BYTES);
    localparam logic [NAME_W-1:0] NAME_LIM = NAME_W'(MAX_NAME);

    logic [POS_W-1:0]   r_pos, n_pos;
    logic [BYTE_W-1:0]  r_rem, n_rem;
    logic               r_jumped, n_jumped;
    logic [JUMP_W-1:0]  r_jumps, n_jumps;
    logic [BYTE_W-1:0]  r_consumed, n_consumed;
    logic [CHARS_W-1:0] r_pack, n_pack;
    logic [CNT_W-1:0]   r_fill, n_fill;
    logic [NAME_W-1:0]  r_name_len, n_name_len;
    logic               r_first, n_first;
    logic [5:0]         r_ptr_hi, n_ptr_hi;
    t_status            r_status, n_status;
    logic [JUMP_W-1:0]  r_max_jumps;
    logic               r_out_valid, n_out_valid;
    logic [OUT_W-1:0]   r_out_data, n_out_data;
    logic               r_out_last, n_out_last;

    logic [POS_W-1:0]   load_pos;
    logic [POS_W-1:0]   pos1;
    logic               mem_we;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [BYTE_W-1:0]  mem_rdata;
    logic               out_free;
    logic [BYTE_W:0]    cons_sum;
    logic [BYTE_W-1:0]  put_c;
    logic [CHARS_W-1:0] put_shift;

    assign load_pos  = POS_W'(i_address);
    assign pos1      = r_pos + POS_W'(1);
    assign mem_we    = i_cmd.load_wr && (load_pos < MSG_END);
    assign mem_re    = i_cmd.rd_pos || i_cmd.rd_pos1;
    assign mem_raddr = i_cmd.rd_pos1 ? pos1[AW-1:0] : r_pos[AW-1:0];
    assign out_free  = !r_out_valid || i_out_ready;

    dnsd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (load_pos[AW-1:0]),
        .i_wdata (i_byte_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign cons_sum  = {1'b0, r_consumed} + (i_cmd.ptr_take ? 9'd2 : 9'd1);
    assign put_c     = i_cmd.put_dot ? DOT_CHAR : mem_rdata;
    assign put_shift = CHARS_W'(put_c) << {r_fill[1:0], 3'b000};

    always_comb begin
        n_pos       = r_pos;
        n_rem       = r_rem;
        n_jumped    = r_jumped;
        n_jumps     = r_jumps;
        n_consumed  = r_consumed;
        n_pack      = r_pack;
        n_fill      = r_fill;
        n_name_len  = r_name_len;
        n_first     = r_first;
        n_ptr_hi    = r_ptr_hi;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (i_cmd.init) begin
            n_pos      = POS_W'(i_start_offset);
            n_rem      = '0;
            n_jumped   = 1'b0;
            n_jumps    = '0;
            n_consumed = '0;
            n_pack     = '0;
            n_fill     = '0;
            n_name_len = '0;
            n_first    = 1'b1;
            n_status   = ST_OK;
        end

        if ((i_cmd.head_zero || i_cmd.head_label || i_cmd.char_adv || i_cmd.ptr_take)
            && !r_jumped) begin
            n_consumed = cons_sum[BYTE_W] ? '1 : cons_sum[BYTE_W-1:0];
        end

        if (i_cmd.head_label) begin
            n_pos   = pos1;
            n_rem   = mem_rdata;
            n_first = 1'b0;
        end

        if (i_cmd.char_adv) begin
            n_pos = pos1;
            n_rem = r_rem - BYTE_W'(1);
        end

        if (i_cmd.ptr_hi) begin
            n_ptr_hi = mem_rdata[5:0];
        end

        if (i_cmd.ptr_take) begin
            n_pos    = POS_W'({r_ptr_hi, mem_rdata});
            n_jumped = 1'b1;
            n_jumps  = r_jumps + JUMP_W'(1);
        end

        if (i_cmd.put_dot || i_cmd.put_byte) begin
            n_name_len = r_name_len + NAME_W'(1);
            if (r_fill == PACK_FULL) begin
                n_out_valid = 1'b1;
                n_out_data  = OUT_W'({BYTE_W'(0), PACK_FULL, r_pack});
                n_out_last  = 1'b0;
                n_pack      = CHARS_W'(put_c);
                n_fill      = CNT_W'(1);
            end else begin
                n_pack = r_pack | put_shift;
                n_fill = r_fill + CNT_W'(1);
            end
        end

        if (i_cmd.set_status) begin
            n_status = i_cmd.status_code;
        end

        if (i_cmd.emit_final) begin
            n_out_valid = 1'b1;
            n_out_data  = OUT_W'({r_status, r_consumed, r_fill, r_pack});
            n_out_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_max_jumps <= JUMPS_RESET;
            r_pos       <= '0;
            r_rem       <= '0;
            r_jumped    <= 1'b0;
            r_jumps     <= '0;
            r_consumed  <= '0;
            r_fill      <= '0;
            r_name_len  <= '0;
            r_first     <= 1'b1;
            r_status    <= ST_OK;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_jumps <= i_cfg_jumps;
            end
            r_pos       <= n_pos;
            r_rem       <= n_rem;
            r_jumped    <= n_jumped;
            r_jumps     <= n_jumps;
            r_consumed  <= n_consumed;
            r_fill      <= n_fill;
            r_name_len  <= n_name_len;
            r_first     <= n_first;
            r_status    <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pack     <= n_pack;
        r_ptr_hi   <= n_ptr_hi;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign o_sts.pos_out   = (r_pos >= MSG_END);
    assign o_sts.pos1_out  = (pos1 >= MSG_END);
    assign o_sts.rem_zero  = (r_rem == '0);
    assign o_sts.byte_zero = (mem_rdata == '0);
    assign o_sts.byte_ptr  = (mem_rdata >= PTR_MARK);
    assign o_sts.jumps_hit = (r_jumps >= r_max_jumps);
    assign o_sts.first     = r_first;
    assign o_sts.name_full = (r_name_len >= NAME_LIM);
    assign o_sts.fill_full = (r_fill == PACK_FULL);
    assign o_sts.out_free  = out_free;

    assign o_max_jumps = r_max_jumps;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

### sv/dnsd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsd_ctrl
// Walk sequencer: load writes, label starts, pointers, label bytes and final beat.
// ----------------------------------------------------------------------------
module dnsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_command,
    output logic           o_in_ready,
    input  dnsd_pkg::t_sts i_sts,
    output dnsd_pkg::t_cmd o_cmd
);

    import dnsd_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (t_command'(i_in_command) == CMD_LOAD) begin
                        o_cmd.load_wr = 1'b1;
                    end else begin
                        o_cmd.init = 1'b1;
                        n_state    = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (i_sts.pos_out) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_RANGE;
                    n_state           = S_FINAL;
                end else begin
                    o_cmd.rd_pos = 1'b1;
                    n_state      = i_sts.rem_zero ? S_HEAD : S_CHAR;
                end
            end
            S_HEAD: begin
                priority if (i_sts.byte_zero) begin
                    o_cmd.head_zero = 1'b1;
                    n_state         = S_FINAL;
                end else if (i_sts.byte_ptr) begin
                    priority if (i_sts.pos1_out) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_RANGE;
                        n_state           = S_FINAL;
                    end else if (i_sts.jumps_hit) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_JUMPS;
                        n_state           = S_FINAL;
                    end else begin
                        o_cmd.ptr_hi  = 1'b1;
                        o_cmd.rd_pos1 = 1'b1;
                        n_state       = S_PTR;
                    end
                end else if (i_sts.first) begin
                    o_cmd.head_label = 1'b1;
                    n_state          = S_FETCH;
                end else if (i_sts.name_full) begin
                    o_cmd.head_label  = 1'b1;
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_LONG;
                    n_state           = S_FINAL;
                end else if (!i_sts.fill_full || i_sts.out_free) begin
                    o_cmd.head_label = 1'b1;
                    o_cmd.put_dot    = 1'b1;
                    n_state          = S_FETCH;
                end else begin
                    n_state = S_HEAD;
                end
            end
            S_PTR: begin
                o_cmd.ptr_take = 1'b1;
                n_state        = S_FETCH;
            end
            S_CHAR: begin
                priority if (i_sts.name_full) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_LONG;
                    n_state           = S_FINAL;
                end else if (!i_sts.fill_full || i_sts.out_free) begin
                    o_cmd.put_byte = 1'b1;
                    o_cmd.char_adv = 1'b1;
                    n_state        = S_FETCH;
                end else begin
                    n_state = S_CHAR;
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/dns_name_decompressor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Loads a DNS message byte by byte and decodes compressed names from it.
// ----------------------------------------------------------------------------
// Channel  Dir  Beat contents
// s_axis   in   tuser: command; tdata: address, byte_value, start_offset
// m_axis   out  tlast: last; tdata: name_chars, char_count, consumed, status
// apb      in   reg 0 at 0x0: max_jumps
//
// A load beat writes one byte to the store. A decode walks label starts, label
// bytes and pointers, then sends the final beat; each step is a store read
// followed by a decision on the registered read data. Input is held off until
// the final beat is registered. A stalled output holds the walk when a full
// four-character word or the final beat must leave. Reset is synchronous; the
// message store is not cleared.
// ----------------------------------------------------------------------------
module dns_name_decompressor #(
    parameter int MSG_BYTES = dnsd_pkg::MSG_BYTES_DEF,
    parameter int MAX_NAME  = dnsd_pkg::MAX_NAME_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // address[8:0], byte_value[16:9], start_offset[25:17]
    input  logic [dnsd_pkg::IN_W-1:0]    s_axis_tdata,
    // command[0]
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // name_chars[31:0], char_count[34:32], consumed[42:35], status[44:43]
    output logic [dnsd_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                         m_axis_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dnsd_pkg::PADDR_W-1:0] paddr,
    input  logic [dnsd_pkg::PDATA_W-1:0] pwdata,
    output logic [dnsd_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import dnsd_pkg::*;

    t_cmd              cmd;
    t_sts              sts;
    logic              cfg_we;
    logic [JUMP_W-1:0] max_jumps;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == '0);
    assign prdata = PDATA_W'(max_jumps);

    dnsd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_command (s_axis_tuser),
        .o_in_ready   (s_axis_tready),
        .i_sts        (sts),
        .o_cmd        (cmd)
    );

    dnsd_datapath #(
        .MSG_BYTES (MSG_BYTES),
        .MAX_NAME  (MAX_NAME)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_address      (s_axis_tdata[8:0]),
        .i_byte_value   (s_axis_tdata[16:9]),
        .i_start_offset (s_axis_tdata[25:17]),
        .i_cfg_we       (cfg_we),
        .i_cfg_jumps    (pwdata[JUMP_W-1:0]),
        .o_max_jumps    (max_jumps),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_out_data     (m_axis_tdata),
        .o_out_last     (m_axis_tlast)
    );

endmodule
